[rtl/sil_pkg.sv]
// ----------------------------------------------------------------------------
// sil_pkg
// Shared types and constants for the sorted insertion list core.
// ----------------------------------------------------------------------------
`default_nettype none

package sil_pkg;

    localparam int SIL_CAPACITY = 64;

    localparam int SIL_KEY_W    = 32;
    localparam int SIL_HANDLE_W = 16;
    localparam int SIL_RANK_W   = 6;
    localparam int SIL_COUNT_W  = 7;
    localparam int SIL_ENTRY_W  = SIL_KEY_W + SIL_HANDLE_W;

    localparam int SIL_IN_W  = 56;
    localparam int SIL_OUT_W = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } sil_op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_RANK_RANGE = 2'd3
    } sil_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ_WAIT,
        S_INS_STEP,
        S_INS_CMP,
        S_DONE
    } sil_state_t;

endpackage

`default_nettype wire

[rtl/sil_ram.sv]
// ----------------------------------------------------------------------------
// sil_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module sil_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/sorted_insertion_list_core.sv]
// ----------------------------------------------------------------------------
// sorted_insertion_list_core
// Bounded list of (signed Q16.16 key, handle) entries kept in descending key
// order, with sorted insert, remove-lowest and read-at-rank.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive as beats on the s_ channel; each beat yields exactly one
//   result beat on the m_ channel carrying status, key, handle and count.
//   The entries live in a single RAM with one write and one registered read
//   port. An insert walks back from the tail, one entry per pass through
//   S_INS_STEP (read) and S_INS_CMP (compare and write), moving each entry
//   whose key is not above the new key down by one place.
//   A rejected or ignored command goes from S_DECODE straight to S_DONE;
//   remove and read pass through S_READ_WAIT; an insert repeats the pass
//   for each moved entry until it reaches the head or stops at a kept entry.
//   s_tready is high only while the core is idle, so one command is worked
//   on at a time; a further command is taken while the previous result
//   still waits in the output register.
//   If the receiver stalls, the result holds in the output register and a
//   finished command waits in its last state until the register frees.
//   After reset the list is empty and s_tready is high at once; RAM contents
//   are never cleared, as only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insertion_list_core
    import sil_pkg::*;
#(
    parameter int CAPACITY = SIL_CAPACITY
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // opcode[1:0], key[33:2], handle[49:34], rank[55:50]
    input  wire logic [SIL_IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status[1:0], out_key[33:2], out_handle[49:34], count[56:50]
    output logic      [SIL_OUT_W-1:0] m_tdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    sil_state_t state_reg, state_next;

    sil_op_t                   op_reg, op_next;
    logic signed [SIL_KEY_W-1:0] key_reg, key_next;
    logic [SIL_HANDLE_W-1:0]   handle_reg, handle_next;
    logic [SIL_RANK_W-1:0]     rank_reg, rank_next;

    logic [CW-1:0]             count_reg, count_next;
    logic [AW-1:0]             idx_reg, idx_next;

    sil_status_t               res_status_reg, res_status_next;
    logic [SIL_KEY_W-1:0]      res_key_reg, res_key_next;
    logic [SIL_HANDLE_W-1:0]   res_handle_reg, res_handle_next;

    logic                      m_tvalid_reg, m_tvalid_next;
    logic [SIL_OUT_W-1:0]      m_tdata_reg, m_tdata_next;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [SIL_ENTRY_W-1:0]    ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [SIL_ENTRY_W-1:0]    ram_rdata;

    logic                      in_beat;
    logic                      out_free;
    logic                      list_full;
    logic                      list_empty;
    logic                      rank_bad;
    logic                      idx_zero;
    logic                      entry_moves;

    assign in_beat     = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign list_full   = (count_reg == CW'(CAPACITY));
    assign list_empty  = (count_reg == '0);
    assign rank_bad    = (32'(rank_reg) >= 32'(count_reg));
    assign idx_zero    = (idx_reg == '0);
    assign entry_moves = ($signed(ram_rdata[SIL_KEY_W-1:0]) <= key_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    sil_ram #(
        .WIDTH (SIL_ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (op_reg)
                    OP_INSERT: state_next = list_full  ? S_DONE : S_INS_STEP;
                    OP_REMOVE: state_next = list_empty ? S_DONE : S_READ_WAIT;
                    OP_READ:   state_next = rank_bad   ? S_DONE : S_READ_WAIT;
                    default:   state_next = S_DONE;
                endcase
            end
            S_READ_WAIT:
            begin
                state_next = S_DONE;
            end
            S_INS_STEP:
            begin
                state_next = idx_zero ? S_DONE : S_INS_CMP;
            end
            S_INS_CMP:
            begin
                state_next = entry_moves ? S_INS_STEP : S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        rank_next       = rank_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_handle_next = res_handle_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = {handle_reg, key_reg};
        ram_re          = 1'b0;
        ram_raddr       = idx_reg - AW'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    op_next     = sil_op_t'(s_tdata[1:0]);
                    key_next    = s_tdata[33:2];
                    handle_next = s_tdata[49:34];
                    rank_next   = s_tdata[55:50];
                end
            end
            S_DECODE:
            begin
                res_status_next = ST_OK;
                res_key_next    = '0;
                res_handle_next = '0;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (list_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            idx_next = AW'(count_reg);
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (list_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(count_reg - CW'(1));
                            count_next = count_reg - CW'(1);
                        end
                    end
                    OP_READ:
                    begin
                        if (rank_bad)
                        begin
                            res_status_next = ST_RANK_RANGE;
                        end
                        else
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = AW'(rank_reg);
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_READ_WAIT:
            begin
                res_key_next    = ram_rdata[SIL_KEY_W-1:0];
                res_handle_next = ram_rdata[SIL_ENTRY_W-1:SIL_KEY_W];
            end
            S_INS_STEP:
            begin
                if (idx_zero)
                begin
                    // reached the head: new entry goes first
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    ram_re = 1'b1;
                end
            end
            S_INS_CMP:
            begin
                ram_we = 1'b1;
                if (entry_moves)
                begin
                    // shift the entry one place towards the tail
                    ram_wdata = ram_rdata;
                    idx_next  = idx_reg - AW'(1);
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, SIL_COUNT_W'(count_reg), res_handle_reg,
                                     res_key_reg, res_status_reg};
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        handle_reg     <= handle_next;
        rank_reg       <= rank_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_handle_reg <= res_handle_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

`default_nettype wire
